// ===== hdl/lightweight_block_cipher_encrypt_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the lightweight block cipher encrypt block
// Clocked, reset-qualified assertion shorthands shared by the RTL.
// ---------------------------------------------------------------------------
`ifndef LIGHTWEIGHT_BLOCK_CIPHER_ENCRYPT_DEFINES_SVH
`define LIGHTWEIGHT_BLOCK_CIPHER_ENCRYPT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset
`define LBCE_ASSERT_NOW(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset
`define LBCE_ASSERT_NEXT(label, pre, post, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error(msg);

`endif

// ===== hdl/lbce_pkg.sv =====
// ---------------------------------------------------------------------------
// lbce_pkg
// Types, constants and round functions of the 64-bit block cipher pipeline.
// ---------------------------------------------------------------------------
package lbce_pkg;

   localparam int ROUND_COUNT = 31;
   localparam int RC_W        = 5;
   localparam int CSR_IDX_W   = 2;
   localparam int CSR_DATA_W  = 64;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_KEY_UPPER = 2'd0,
      CSR_KEY_LOWER = 2'd1,
      CSR_KEY_MODE  = 2'd2
   } csr_index_type;

   // Key register state; in 80-bit mode only hi[15:0] is live
   typedef struct packed {
      logic        wide;
      logic [63:0] hi;
      logic [63:0] lo;
   } key_state_type;

   // One pipeline stage: valid bit, key state and cipher state travel together
   typedef struct packed {
      logic          valid;
      key_state_type key;
      logic [63:0]   state;
   } stage_type;

   localparam logic [3:0] SBOX [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   function automatic logic [3:0] sbox(logic [3:0] x);
      return SBOX[x];
   endfunction

   function automatic logic [63:0] sub_layer(logic [63:0] s);
      logic [63:0] r;
      for (int n = 0; n < 16; n++) begin
         r[4*n +: 4] = sbox(s[4*n +: 4]);
      end
      return r;
   endfunction

   // Bit b moves to 16*b mod 63; bit 63 stays
   function automatic logic [63:0] perm_layer(logic [63:0] s);
      logic [63:0] r;
      for (int b = 0; b < 63; b++) begin
         r[(b * 16) % 63] = s[b];
      end
      r[63] = s[63];
      return r;
   endfunction

   function automatic logic [63:0] round_key(key_state_type k);
      return k.wide ? k.hi : {k.hi[15:0], k.lo[63:16]};
   endfunction

   // Advance the key schedule by one round with round counter rc
   function automatic key_state_type key_next(key_state_type k, logic [RC_W-1:0] rc);
      key_state_type r;
      logic [15:0]   nh16;
      r.wide = k.wide;
      if (!k.wide) begin
         nh16         = k.lo[18:3];
         nh16[15:12]  = sbox(nh16[15:12]);
         r.hi         = {48'd0, nh16};
         r.lo         = {k.lo[2:0], k.hi[15:0], k.lo[63:19]};
         r.lo[19:15]  = r.lo[19:15] ^ rc;
      end else begin
         r.hi         = {k.hi[2:0], k.lo[63:3]};
         r.lo         = {k.lo[2:0], k.hi[63:3]};
         r.hi[63:60]  = sbox(r.hi[63:60]);
         r.hi[59:56]  = sbox(r.hi[59:56]);
         r.hi[2:0]    = r.hi[2:0] ^ rc[4:2];
         r.lo[63:62]  = r.lo[63:62] ^ rc[1:0];
      end
      return r;
   endfunction

endpackage

// ===== hdl/lbce_csr.sv =====
// ---------------------------------------------------------------------------
// lbce_csr
// Key and mode registers; presents the initial key schedule state.
// ---------------------------------------------------------------------------
module lbce_csr (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [lbce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbce_pkg::CSR_DATA_W-1:0] csr_wdata,
   output lbce_pkg::key_state_type         key_init
);
   import lbce_pkg::*;

   logic [63:0] key_upper_ff;
   logic [63:0] key_lower_ff;
   logic        key_mode_ff;

   // Take register writes; unknown indexes are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         key_upper_ff <= '0;
         key_lower_ff <= '0;
         key_mode_ff  <= 1'b0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_KEY_UPPER: key_upper_ff <= csr_wdata;
            CSR_KEY_LOWER: key_lower_ff <= csr_wdata;
            CSR_KEY_MODE:  key_mode_ff  <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Mask the unused upper key bits in 80-bit mode
   always_comb begin
      key_init.wide = key_mode_ff;
      key_init.hi   = key_mode_ff ? key_upper_ff : {48'd0, key_upper_ff[15:0]};
      key_init.lo   = key_lower_ff;
   end

endmodule

// ===== hdl/lbce_round.sv =====
// ---------------------------------------------------------------------------
// lbce_round
// One registered cipher round: key add, S-box layer, bit permutation, key step.
// ---------------------------------------------------------------------------
module lbce_round (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         advance,
   input  logic [lbce_pkg::RC_W-1:0]    round_num,
   input  lbce_pkg::stage_type          stage_i,
   output lbce_pkg::stage_type          stage_o
);
   import lbce_pkg::*;

   logic          valid_ff;
   key_state_type key_ff;
   logic [63:0]   state_ff;
   key_state_type key_in;
   logic [63:0]   state_in;

   // Round datapath
   always_comb begin
      state_in = perm_layer(sub_layer(stage_i.state ^ round_key(stage_i.key)));
      key_in   = key_next(stage_i.key, round_num);
   end

   // Advance the valid bit
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (advance) begin
         valid_ff <= stage_i.valid;
      end
   end

   // Advance the payload; hold while stalled
   always_ff @(posedge clock) begin
      if (advance) begin
         key_ff   <= key_in;
         state_ff <= state_in;
      end
   end

   assign stage_o.valid = valid_ff;
   assign stage_o.key   = key_ff;
   assign stage_o.state = state_ff;

endmodule

// ===== hdl/lightweight_block_cipher_encrypt.sv =====
// Path from item accept to result valid: 31 round stages, then the output register.
// Throughput: one item per cycle unless stalled; each round has a stage, the key rides along.
// A stalled result freezes the whole pipeline; no item is lost or repeated.
// Reset (synchronous, active high) clears all valid bits and the key/mode registers.
// ---------------------------------------------------------------------------
// lightweight_block_cipher_encrypt
// Fully unrolled 31-round 64-bit block cipher encryptor, 80/128-bit keys.
// ---------------------------------------------------------------------------
`include "lightweight_block_cipher_encrypt_defines.svh"

module lightweight_block_cipher_encrypt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [lbce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [lbce_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [63:0]                     req_plaintext,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [63:0]                     rsp_ciphertext
);
   import lbce_pkg::*;

   key_state_type key_init;
   stage_type     stage [ROUND_COUNT+1];
   logic          advance;
   logic          rsp_valid_ff;
   logic [63:0]   rsp_ciphertext_ff;
   logic [63:0]   rsp_ciphertext_in;

   lbce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .key_init  (key_init)
   );

   // Move the pipeline unless a finished item waits at the output
   assign advance   = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !advance;

   // Feed the first round straight from the input item
   always_comb begin
      stage[0].valid = req_valid;
      stage[0].key   = key_init;
      stage[0].state = req_plaintext;
   end

   for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
      lbce_round u_round (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .round_num (RC_W'(i + 1)),
         .stage_i   (stage[i]),
         .stage_o   (stage[i+1])
      );
   end

   // Add the final round key
   assign rsp_ciphertext_in = stage[ROUND_COUNT].state ^ round_key(stage[ROUND_COUNT].key);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= stage[ROUND_COUNT].valid;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ciphertext_ff <= rsp_ciphertext_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_ciphertext = rsp_ciphertext_ff;

   // An accepted item shows up in the first round register
   `LBCE_ASSERT_NEXT(a_accept_enters,
      req_valid && !req_stall,
      stage[1].valid,
      "accepted item not in first stage")
   // A stalled output freezes the last round stage
   `LBCE_ASSERT_NEXT(a_stall_holds_last,
      rsp_valid && rsp_stall,
      $stable(stage[ROUND_COUNT].valid) && $stable(stage[ROUND_COUNT].state),
      "last stage moved under stall")
   // The 80-bit key schedule never sets the upper key bits
   `LBCE_ASSERT_NOW(a_narrow_key_clean,
      stage[ROUND_COUNT].valid && !stage[ROUND_COUNT].key.wide,
      stage[ROUND_COUNT].key.hi[63:16] == 48'd0,
      "80-bit key state has upper bits set")

endmodule

// ===== tb/sv/tb_lightweight_block_cipher_encrypt.sv =====
// ----------------------------------------------------------------------------
// Testbench for the 64-bit block cipher encryptor
// Drives plaintext items under random gaps and result stalls, programs 80-bit
// and 128-bit keys between phases while the pipeline is empty, and compares
// every ciphertext against an in-order bit-level model of the cipher.
// ----------------------------------------------------------------------------
module tb_lightweight_block_cipher_encrypt;
   timeunit 1ns;
   timeprecision 1ps;

   import lbce_pkg::*;

   localparam int          CYCLE_LIMIT     = 300000;
   localparam int          RANDOM_ITEMS    = 650;
   localparam int          SETTLE_CYCLES   = 40;
   localparam logic [1:0]  CSR_UNMAPPED    = 2'd3;
   localparam logic [63:0] ALL_ONES        = 64'hffff_ffff_ffff_ffff;

   // 4-bit substitution table of the cipher
   localparam logic [3:0] NIB_SUB [16] = '{
      4'hc, 4'h5, 4'h6, 4'hb, 4'h9, 4'h0, 4'ha, 4'hd,
      4'h3, 4'he, 4'hf, 4'h8, 4'h4, 4'h7, 4'h1, 4'h2
   };

   // Key registers mirror and queue of ciphertexts still owed by the block
   class cipher_ledger;
      logic [63:0] key_upper = '0;
      logic [63:0] key_lower = '0;
      logic        wide_key  = 1'b0;
      logic [63:0] owed_ciphers [$];
      int          errors    = 0;

      function void write_reg(logic [1:0] idx, logic [63:0] data);
         case (idx)
            CSR_KEY_UPPER: key_upper = data;
            CSR_KEY_LOWER: key_lower = data;
            CSR_KEY_MODE:  wide_key  = data[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] encrypt_block(logic [63:0] plain);
         logic [127:0] k;
         logic [63:0]  s;
         logic [63:0]  t;
         k = wide_key ? {key_upper, key_lower} : {48'd0, key_upper[15:0], key_lower};
         s = plain;
         for (int rnd = 1; rnd <= ROUND_COUNT; rnd++) begin
            // add round key, substitute nibbles, scatter bits
            s ^= wide_key ? k[127:64] : k[79:16];
            for (int n = 0; n < 16; n++) begin
               s[4*n +: 4] = NIB_SUB[s[4*n +: 4]];
            end
            t = '0;
            for (int b = 0; b < 64; b++) begin
               t[(b == 63) ? 63 : (b * 16) % 63] = s[b];
            end
            s = t;
            // rotate the key left by 61, substitute top nibbles, fold in counter
            if (wide_key) begin
               k = {k[66:0], k[127:67]};
               k[127:124] = NIB_SUB[k[127:124]];
               k[123:120] = NIB_SUB[k[123:120]];
               k[66:62]   = k[66:62] ^ 5'(rnd);
            end else begin
               k[79:0]   = {k[18:0], k[79:19]};
               k[79:76]  = NIB_SUB[k[79:76]];
               k[19:15]  = k[19:15] ^ 5'(rnd);
            end
         end
         return s ^ (wide_key ? k[127:64] : k[79:16]);
      endfunction

      function void note_plaintext(logic [63:0] plain);
         owed_ciphers.push_back(encrypt_block(plain));
      endfunction

      function void check_ciphertext(logic [63:0] cipher);
         logic [63:0] want;
         if (owed_ciphers.size() == 0) begin
            $display("%0t: unexpected ciphertext %h", $time, cipher);
            errors++;
         end else begin
            want = owed_ciphers.pop_front();
            if (cipher !== want) begin
               $display("%0t: ciphertext expected %h actual %h", $time, want, cipher);
               errors++;
            end
         end
      endfunction

      function int pending();
         return owed_ciphers.size();
      endfunction
   endclass

   logic        clock          = 1'b0;
   logic        reset          = 1'b1;
   logic        csr_write      = 1'b0;
   logic [1:0]  csr_index      = '0;
   logic [63:0] csr_wdata      = '0;
   logic        req_valid      = 1'b0;
   logic        req_stall;
   logic [63:0] req_plaintext  = '0;
   logic        rsp_valid;
   logic        rsp_stall      = 1'b1;
   logic [63:0] rsp_ciphertext;

   bit          sender_idles   = 1'b1;
   bit          receiver_idles = 1'b1;
   int          cycle_count    = 0;

   cipher_ledger ledger = new();

   lightweight_block_cipher_encrypt uut (
      .clock          (clock),
      .reset          (reset),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_plaintext  (req_plaintext),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_ciphertext (rsp_ciphertext)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // Offer one plaintext item, optionally after a random gap, and hold it until taken
   task automatic send_block(input logic [63:0] plain);
      int gap;
      gap = sender_idles ? $urandom_range(0, 5) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_plaintext <= plain;
      do @(posedge clock); while (req_stall);
      ledger.note_plaintext(plain);
   endtask

   // Present one register write; the caller drops csr_write after the last one
   task automatic write_csr(input logic [1:0] idx, input logic [63:0] data);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      ledger.write_reg(idx, data);
   endtask

   // Stop offering items and wait for every owed ciphertext
   task automatic drain_results();
      req_valid <= 1'b0;
      while (ledger.pending() != 0) @(posedge clock);
   endtask

   // Result side: stall a random number of cycles per item, then take it
   initial begin
      int hold;
      while (reset) @(posedge clock);
      forever begin
         hold = receiver_idles ? $urandom_range(0, 5) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         ledger.check_ciphertext(rsp_ciphertext);
      end
   end

   initial begin
      logic [63:0] corners [6];
      logic [63:0] plain;
      logic [63:0] key_word;
      int          sent;
      int          burst;

      corners = '{64'h0, ALL_ONES, 64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa,
                  64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001};

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset key, 80-bit mode: extremes of the block
      foreach (corners[i]) send_block(corners[i]);
      drain_results();

      // Full key with the unused upper key bits set; mode value with only bit 0 clear
      write_csr(CSR_KEY_UPPER, ALL_ONES);
      write_csr(CSR_KEY_LOWER, ALL_ONES);
      write_csr(CSR_KEY_MODE, 64'hffff_ffff_ffff_fffe);
      csr_write <= 1'b0;
      send_block(64'h0);
      send_block(ALL_ONES);
      drain_results();

      // Wide mode from a value with every bit set
      write_csr(CSR_KEY_MODE, ALL_ONES);
      csr_write <= 1'b0;
      send_block(64'h0);
      send_block(ALL_ONES);
      send_block(64'h0123_4567_89ab_cdef);
      drain_results();

      // Writes to the unmapped index change nothing
      write_csr(CSR_UNMAPPED, 64'h0);
      write_csr(CSR_UNMAPPED, 64'h1234_5678_9abc_def0);
      csr_write <= 1'b0;
      send_block(64'hfedc_ba98_7654_3210);
      send_block(64'h0);
      drain_results();

      // All-zero 128-bit key
      write_csr(CSR_KEY_UPPER, 64'h0);
      write_csr(CSR_KEY_LOWER, 64'h0);
      csr_write <= 1'b0;
      send_block(64'h0);
      send_block(ALL_ONES);
      drain_results();

      // Random phases: new keys while empty, then a burst of items
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         burst = $urandom_range(20, 80);
         for (int r = 0; r < 3; r++) begin
            if ($urandom_range(0, 3) != 0) begin
               case ($urandom_range(0, 5))
                  0:       key_word = '0;
                  1:       key_word = ALL_ONES;
                  default: key_word = {$urandom, $urandom};
               endcase
               write_csr(r[1:0], key_word);
            end
         end
         if ($urandom_range(0, 7) == 0) write_csr(CSR_UNMAPPED, {$urandom, $urandom});
         csr_write      <= 1'b0;
         sender_idles   = ($urandom_range(0, 3) != 0);
         receiver_idles = ($urandom_range(0, 3) != 0);
         repeat (burst) begin
            case ($urandom_range(0, 7))
               0:       plain = 64'h1 << $urandom_range(0, 63);
               1:       plain = ~(64'h1 << $urandom_range(0, 63));
               2:       plain = corners[$urandom_range(0, 5)];
               default: plain = {$urandom, $urandom};
            endcase
            send_block(plain);
         end
         drain_results();
         sent += burst;
      end

      // Let any stray result surface
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (ledger.errors == 0 && ledger.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
